// File: rtl/core/gap_fill_linear_interpolator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gap fill interpolator core
// Implication checks on a clock with an active low reset.
// ----------------------------------------------------------------------------
`ifndef GAP_FILL_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH
`define GAP_FILL_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH

// same-cycle implication
`define GFLI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define GFLI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/gfli_pkg.sv
// ----------------------------------------------------------------------------
// gfli_pkg
// Types and constants shared by the gap fill interpolator modules.
// ----------------------------------------------------------------------------
package gfli_pkg;

    localparam int HOLD_DEPTH_DEF = 32;

    localparam logic [15:0] EDGE_VALUE_RST  = 16'd1024;
    localparam logic [15:0] EDGE_MARGIN_RST = 16'd42;

    localparam logic REG_EDGE_VALUE  = 1'b0;
    localparam logic REG_EDGE_MARGIN = 1'b1;

    typedef enum logic [1:0] {
        CMD_EDGE,
        CMD_HOLD,
        CMD_CLOSE,
        CMD_RIGHT
    } t_cmd_kind;

    typedef enum logic [1:0] {
        PH_WAIT_FIRST,
        PH_SEEK,
        PH_COLLECT
    } t_phase;

    typedef enum logic [3:0] {
        B_IDLE,
        B_EDGE,
        B_SCAN_A,
        B_SCAN_B,
        B_FILL_A,
        B_FILL_B,
        B_BLOOD,
        B_BLOOD_W,
        B_TISSUE,
        B_TISSUE_W,
        B_FILL_OUT,
        B_CLOSE_OUT,
        B_RIGHT
    } t_bstate;

    typedef enum logic [2:0] {
        I_IDLE,
        I_MUL,
        I_CMP,
        I_DIV,
        I_FIN
    } t_istate;

    // one command from the front to the back
    typedef struct packed {
        t_cmd_kind   kind;
        logic        tail;      // right edge follows
        logic        sticky;
        logic [31:0] t;
        logic [15:0] b;
        logic [15:0] s;
        logic [31:0] abt;
        logic [15:0] abl;
        logic [31:0] att;
        logic [15:0] atl;
        logic [31:0] rt;
        logic [15:0] ev;
    } t_cmd;

endpackage

// File: rtl/core/gfli_front.sv
// ----------------------------------------------------------------------------
// gfli_front
// Segment tracking, anchors and hold accounting; issues back commands.
// ----------------------------------------------------------------------------
module gfli_front #(
    parameter int HOLD_DEPTH = gfli_pkg::HOLD_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_addr,
    input  logic [15:0]     i_cfg_wdata,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [31:0]     i_time,
    input  logic [15:0]     i_blood,
    input  logic [15:0]     i_tissue,
    input  logic            i_last,
    output logic            o_push,
    output gfli_pkg::t_cmd  o_cmd,
    input  logic            i_q_ready
);
    localparam int CW = $clog2(HOLD_DEPTH + 1);

    gfli_pkg::t_phase r_phase, n_phase;
    logic [1:0]       r_seen, n_seen;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [31:0]      r_abt, n_abt, r_att, n_att, r_bvt, n_bvt;
    logic [15:0]      r_abl, n_abl, r_atl, n_atl;
    logic             r_sticky, n_sticky;
    logic [15:0]      r_ev, r_margin;

    logic        accept, need;
    logic [15:0] ev;
    logic [31:0] et;
    logic [32:0] rsum;
    logic [31:0] rbase;
    logic        bv, sv, go;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;
    assign o_push  = accept && need;

    assign ev = (r_ev == 16'd0) ? 16'd1 : r_ev;
    assign et = (i_time >= {16'd0, r_margin}) ? i_time - {16'd0, r_margin} : 32'd0;
    assign bv = (i_blood != 16'd0);
    assign sv = (i_tissue != 16'd0);
    assign rsum = {1'b0, rbase} + {17'd0, r_margin};

    always_comb begin
        n_phase  = r_phase;
        n_seen   = r_seen;
        n_cnt    = r_cnt;
        n_abt    = r_abt;
        n_abl    = r_abl;
        n_att    = r_att;
        n_atl    = r_atl;
        n_bvt    = r_bvt;
        n_sticky = r_sticky;
        need     = 1'b0;
        go       = 1'b0;
        rbase    = r_bvt;
        o_cmd        = '0;
        o_cmd.t      = i_time;
        o_cmd.b      = i_blood;
        o_cmd.s      = i_tissue;
        o_cmd.abt    = r_abt;
        o_cmd.abl    = r_abl;
        o_cmd.att    = r_att;
        o_cmd.atl    = r_atl;
        o_cmd.ev     = ev;
        o_cmd.kind   = gfli_pkg::CMD_RIGHT;
        case (r_phase)
            gfli_pkg::PH_WAIT_FIRST: begin
                need       = 1'b1;
                o_cmd.kind = gfli_pkg::CMD_EDGE;
                o_cmd.t    = et;
                o_cmd.tail = i_last;
                n_abt = et;
                n_att = et;
                n_abl = ev;
                n_atl = ev;
                n_bvt = i_time;
                rbase = i_time;
                n_seen  = 2'b00;
                n_cnt   = '0;
                n_phase = i_last ? gfli_pkg::PH_WAIT_FIRST : gfli_pkg::PH_SEEK;
            end
            gfli_pkg::PH_SEEK, gfli_pkg::PH_COLLECT: begin
                n_seen = r_seen | {sv, bv};
                go = (r_phase == gfli_pkg::PH_COLLECT) || (n_seen == 2'b11);
                if (go) begin
                    n_phase = gfli_pkg::PH_COLLECT;
                end
                if (go && bv && sv) begin
                    need       = 1'b1;
                    o_cmd.kind = gfli_pkg::CMD_CLOSE;
                    o_cmd.tail = i_last;
                    n_abt = i_time;
                    n_att = i_time;
                    n_abl = i_blood;
                    n_atl = i_tissue;
                    n_bvt = i_time;
                    rbase = i_time;
                    n_cnt = '0;
                    if (i_last) begin
                        n_phase = gfli_pkg::PH_WAIT_FIRST;
                    end
                end else if (i_last) begin
                    need       = 1'b1;
                    o_cmd.kind = gfli_pkg::CMD_RIGHT;
                    n_cnt   = '0;
                    n_phase = gfli_pkg::PH_WAIT_FIRST;
                end else if (go) begin
                    if (r_cnt < CW'(HOLD_DEPTH)) begin
                        need       = 1'b1;
                        o_cmd.kind = gfli_pkg::CMD_HOLD;
                        n_cnt = r_cnt + CW'(1);
                    end else begin
                        n_sticky = 1'b1;
                    end
                end
            end
            default: begin
                n_phase = gfli_pkg::PH_WAIT_FIRST;
            end
        endcase
        o_cmd.rt     = rsum[32] ? 32'hFFFF_FFFF : rsum[31:0];
        o_cmd.sticky = n_sticky;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= gfli_pkg::PH_WAIT_FIRST;
            r_seen   <= 2'b00;
            r_cnt    <= '0;
            r_abt    <= '0;
            r_abl    <= '0;
            r_att    <= '0;
            r_atl    <= '0;
            r_bvt    <= '0;
            r_sticky <= 1'b0;
            r_ev     <= gfli_pkg::EDGE_VALUE_RST;
            r_margin <= gfli_pkg::EDGE_MARGIN_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    gfli_pkg::REG_EDGE_VALUE:  r_ev     <= i_cfg_wdata;
                    gfli_pkg::REG_EDGE_MARGIN: r_margin <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (accept) begin
                r_phase  <= n_phase;
                r_seen   <= n_seen;
                r_cnt    <= n_cnt;
                r_abt    <= n_abt;
                r_abl    <= n_abl;
                r_att    <= n_att;
                r_atl    <= n_atl;
                r_bvt    <= n_bvt;
                r_sticky <= n_sticky;
            end
        end
    end

endmodule

// File: rtl/core/gfli_queue.sv
// ----------------------------------------------------------------------------
// gfli_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module gfli_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gfli_pkg::t_cmd  i_cmd,
    output logic            o_ready,
    output logic            o_valid,
    output gfli_pkg::t_cmd  o_cmd,
    input  logic            i_pop
);
    gfli_pkg::t_cmd r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           do_push, do_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// File: rtl/core/gfli_interp.sv
// ----------------------------------------------------------------------------
// gfli_interp
// Sequential linear interpolation: a + round((tc-ta)*(b-a)/(tb-ta)).
// ----------------------------------------------------------------------------
module gfli_interp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_ta,
    input  logic [15:0] i_a,
    input  logic [31:0] i_tb,
    input  logic [15:0] i_b,
    input  logic [31:0] i_tc,
    output logic        o_done,
    output logic [15:0] o_res
);
    gfli_pkg::t_istate r_state, n_state;

    logic [31:0] r_den, r_dt;
    logic [15:0] r_dl, r_a;
    logic        r_neg, r_dz, r_sat;
    logic [47:0] r_prod;
    logic [49:0] r_rem, r_dsh;
    logic [16:0] r_q;
    logic [4:0]  r_bit;
    logic        r_done;
    logic [15:0] r_res;

    logic [32:0] den, dt;
    logic [16:0] dl;
    logic [49:0] num2, thr;
    logic        ge;
    logic [18:0] sum;

    assign den  = {1'b0, i_tb} - {1'b0, i_ta};
    assign dt   = {1'b0, i_tc} - {1'b0, i_ta};
    assign dl   = {1'b0, i_b} - {1'b0, i_a};
    // rounding: q = floor((2n + d) / 2d)
    assign num2 = {1'b0, r_prod, 1'b0} + {18'd0, r_den};
    assign thr  = {r_den, 18'd0};
    assign ge   = (r_rem >= r_dsh);
    assign sum  = r_neg ? {3'd0, r_a} - {2'd0, r_q} : {3'd0, r_a} + {2'd0, r_q};

    assign o_done = r_done;
    assign o_res  = r_res;

    always_comb begin
        n_state = r_state;
        case (r_state)
            gfli_pkg::I_IDLE: if (i_start) n_state = gfli_pkg::I_MUL;
            gfli_pkg::I_MUL:  n_state = gfli_pkg::I_CMP;
            gfli_pkg::I_CMP: begin
                n_state = (r_dz || (num2 >= thr)) ? gfli_pkg::I_FIN : gfli_pkg::I_DIV;
            end
            gfli_pkg::I_DIV:  if (r_bit == 5'd0) n_state = gfli_pkg::I_FIN;
            gfli_pkg::I_FIN:  n_state = gfli_pkg::I_IDLE;
            default:          n_state = gfli_pkg::I_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gfli_pkg::I_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == gfli_pkg::I_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            gfli_pkg::I_IDLE: begin
                r_den <= den[32] ? 32'(-den) : den[31:0];
                r_dt  <= dt[32] ? 32'(-dt) : dt[31:0];
                r_dl  <= dl[16] ? 16'(-dl) : dl[15:0];
                r_neg <= den[32] ^ dt[32] ^ dl[16];
                r_dz  <= (den == 33'd0);
                r_a   <= i_a;
            end
            gfli_pkg::I_MUL: begin
                r_prod <= r_dt * r_dl;
            end
            gfli_pkg::I_CMP: begin
                r_sat <= !r_dz && (num2 >= thr);
                r_rem <= num2;
                r_dsh <= {1'b0, r_den, 17'd0};
                r_q   <= '0;
                r_bit <= 5'd16;
            end
            gfli_pkg::I_DIV: begin
                if (ge) r_rem <= r_rem - r_dsh;
                r_q   <= {r_q[15:0], ge};
                r_dsh <= {1'b0, r_dsh[49:1]};
                r_bit <= r_bit - 5'd1;
            end
            gfli_pkg::I_FIN: begin
                if (r_dz) begin
                    r_res <= r_a;
                end else if (r_sat) begin
                    r_res <= r_neg ? 16'd1 : 16'hFFFF;
                end else if (sum[18] || sum == 19'd0) begin
                    r_res <= 16'd1;
                end else if (sum[17:16] != 2'd0) begin
                    r_res <= 16'hFFFF;
                end else begin
                    r_res <= sum[15:0];
                end
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/core/gfli_back.sv
// ----------------------------------------------------------------------------
// gfli_back
// Executes commands: hold buffer, gap fill walk and result output register.
// ----------------------------------------------------------------------------
module gfli_back #(
    parameter int HOLD_DEPTH = gfli_pkg::HOLD_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  gfli_pkg::t_cmd  i_cmd,
    output logic            o_cmd_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [31:0]     o_time,
    output logic [15:0]     o_blood,
    output logic [15:0]     o_tissue,
    output logic            o_edge,
    output logic            o_eos,
    output logic            o_ovf
);
    localparam int IW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CW = $clog2(HOLD_DEPTH + 1);

    gfli_pkg::t_bstate r_state, n_state;
    gfli_pkg::t_cmd    r_cmd;

    logic [63:0]   r_held [HOLD_DEPTH];
    logic [95:0]   r_nxt  [HOLD_DEPTH];
    logic [63:0]   r_held_rd;
    logic [95:0]   r_nxt_rd;
    logic [CW-1:0] r_cnt;
    logic [IW-1:0] r_idx;

    // running anchors: next valid point on the scan, previous on the fill
    logic [31:0] r_rbt, r_rst;
    logic [15:0] r_rbl, r_rsl;
    logic [31:0] r_et, r_nbt, r_nst;
    logic [15:0] r_eb, r_es, r_nbl, r_nsl, r_fb, r_fs;

    logic        r_ov;
    logic [31:0] r_ot;
    logic [15:0] r_ob, r_os;
    logic        r_oe, r_oeos, r_oovf;

    logic        slot, emit, held_we, last_ent;
    logic [31:0] e_t;
    logic [15:0] e_b, e_s;
    logic        e_edge, e_eos;

    logic        istart, idone;
    logic [31:0] ita, itb;
    logic [15:0] ia, ib, ires;

    gfli_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (istart),
        .i_ta    (ita),
        .i_a     (ia),
        .i_tb    (itb),
        .i_b     (ib),
        .i_tc    (r_et),
        .o_done  (idone),
        .o_res   (ires)
    );

    assign slot     = !r_ov || i_ready;
    assign held_we  = (r_state == gfli_pkg::B_IDLE) && i_cmd_valid
                      && (i_cmd.kind == gfli_pkg::CMD_HOLD);
    assign last_ent = (CW'(r_idx) == r_cnt - CW'(1));

    assign o_valid  = r_ov;
    assign o_time   = r_ot;
    assign o_blood  = r_ob;
    assign o_tissue = r_os;
    assign o_edge   = r_oe;
    assign o_eos    = r_oeos;
    assign o_ovf    = r_oovf;

    always_comb begin
        n_state   = r_state;
        o_cmd_pop = 1'b0;
        emit      = 1'b0;
        e_t       = r_cmd.t;
        e_b       = r_cmd.ev;
        e_s       = r_cmd.ev;
        e_edge    = 1'b0;
        e_eos     = 1'b0;
        istart    = 1'b0;
        ita       = r_rbt;
        ia        = r_rbl;
        itb       = r_nbt;
        ib        = r_nbl;
        case (r_state)
            gfli_pkg::B_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.kind)
                        gfli_pkg::CMD_EDGE:  n_state = gfli_pkg::B_EDGE;
                        gfli_pkg::CMD_HOLD:  n_state = gfli_pkg::B_IDLE;
                        gfli_pkg::CMD_CLOSE: begin
                            n_state = (r_cnt == '0) ? gfli_pkg::B_CLOSE_OUT
                                                    : gfli_pkg::B_SCAN_A;
                        end
                        gfli_pkg::CMD_RIGHT: n_state = gfli_pkg::B_RIGHT;
                        default:             n_state = gfli_pkg::B_IDLE;
                    endcase
                end
            end
            gfli_pkg::B_EDGE: begin
                if (slot) begin
                    emit    = 1'b1;
                    e_edge  = 1'b1;
                    n_state = r_cmd.tail ? gfli_pkg::B_RIGHT : gfli_pkg::B_IDLE;
                end
            end
            gfli_pkg::B_SCAN_A: n_state = gfli_pkg::B_SCAN_B;
            gfli_pkg::B_SCAN_B: begin
                n_state = (r_idx == '0) ? gfli_pkg::B_FILL_A : gfli_pkg::B_SCAN_A;
            end
            gfli_pkg::B_FILL_A: n_state = gfli_pkg::B_FILL_B;
            gfli_pkg::B_FILL_B: n_state = gfli_pkg::B_BLOOD;
            gfli_pkg::B_BLOOD: begin
                if (r_eb != 16'd0) begin
                    n_state = gfli_pkg::B_TISSUE;
                end else begin
                    istart  = 1'b1;
                    n_state = gfli_pkg::B_BLOOD_W;
                end
            end
            gfli_pkg::B_BLOOD_W: if (idone) n_state = gfli_pkg::B_TISSUE;
            gfli_pkg::B_TISSUE: begin
                ita = r_rst;
                ia  = r_rsl;
                itb = r_nst;
                ib  = r_nsl;
                if (r_es != 16'd0) begin
                    n_state = gfli_pkg::B_FILL_OUT;
                end else begin
                    istart  = 1'b1;
                    n_state = gfli_pkg::B_TISSUE_W;
                end
            end
            gfli_pkg::B_TISSUE_W: if (idone) n_state = gfli_pkg::B_FILL_OUT;
            gfli_pkg::B_FILL_OUT: begin
                e_t = r_et;
                e_b = r_fb;
                e_s = r_fs;
                if (slot) begin
                    emit    = 1'b1;
                    n_state = last_ent ? gfli_pkg::B_CLOSE_OUT : gfli_pkg::B_FILL_A;
                end
            end
            gfli_pkg::B_CLOSE_OUT: begin
                e_b = r_cmd.b;
                e_s = r_cmd.s;
                if (slot) begin
                    emit    = 1'b1;
                    n_state = r_cmd.tail ? gfli_pkg::B_RIGHT : gfli_pkg::B_IDLE;
                end
            end
            gfli_pkg::B_RIGHT: begin
                e_t    = r_cmd.rt;
                e_edge = 1'b1;
                e_eos  = 1'b1;
                if (slot) begin
                    emit    = 1'b1;
                    n_state = gfli_pkg::B_IDLE;
                end
            end
            default: n_state = gfli_pkg::B_IDLE;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (held_we) begin
            r_held[r_cnt[IW-1:0]] <= {i_cmd.t, i_cmd.b, i_cmd.s};
        end
        r_held_rd <= r_held[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == gfli_pkg::B_SCAN_B) begin
            r_nxt[r_idx] <= {r_rbt, r_rbl, r_rst, r_rsl};
        end
        r_nxt_rd <= r_nxt[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gfli_pkg::B_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (held_we) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (emit && (r_state == gfli_pkg::B_CLOSE_OUT || r_state == gfli_pkg::B_RIGHT)) begin
                r_cnt <= '0;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_ot   <= e_t;
            r_ob   <= e_b;
            r_os   <= e_s;
            r_oe   <= e_edge;
            r_oeos <= e_eos;
            r_oovf <= r_cmd.sticky;
        end
        case (r_state)
            gfli_pkg::B_IDLE: begin
                if (i_cmd_valid) begin
                    r_cmd <= i_cmd;
                    r_idx <= IW'(r_cnt - CW'(1));
                    r_rbt <= i_cmd.t;
                    r_rbl <= i_cmd.b;
                    r_rst <= i_cmd.t;
                    r_rsl <= i_cmd.s;
                end
            end
            gfli_pkg::B_SCAN_B: begin
                if (r_idx == '0) begin
                    // scan done: switch to the previous-point anchors
                    r_rbt <= r_cmd.abt;
                    r_rbl <= r_cmd.abl;
                    r_rst <= r_cmd.att;
                    r_rsl <= r_cmd.atl;
                end else begin
                    if (r_held_rd[31:16] != 16'd0) begin
                        r_rbt <= r_held_rd[63:32];
                        r_rbl <= r_held_rd[31:16];
                    end
                    if (r_held_rd[15:0] != 16'd0) begin
                        r_rst <= r_held_rd[63:32];
                        r_rsl <= r_held_rd[15:0];
                    end
                    r_idx <= r_idx - IW'(1);
                end
            end
            gfli_pkg::B_FILL_B: begin
                r_et  <= r_held_rd[63:32];
                r_eb  <= r_held_rd[31:16];
                r_es  <= r_held_rd[15:0];
                r_nbt <= r_nxt_rd[95:64];
                r_nbl <= r_nxt_rd[63:48];
                r_nst <= r_nxt_rd[47:16];
                r_nsl <= r_nxt_rd[15:0];
            end
            gfli_pkg::B_BLOOD: begin
                if (r_eb != 16'd0) begin
                    r_fb  <= r_eb;
                    r_rbt <= r_et;
                    r_rbl <= r_eb;
                end
            end
            gfli_pkg::B_BLOOD_W: if (idone) r_fb <= ires;
            gfli_pkg::B_TISSUE: begin
                if (r_es != 16'd0) begin
                    r_fs  <= r_es;
                    r_rst <= r_et;
                    r_rsl <= r_es;
                end
            end
            gfli_pkg::B_TISSUE_W: if (idone) r_fs <= ires;
            gfli_pkg::B_FILL_OUT: begin
                if (slot && !last_ent) r_idx <= r_idx + IW'(1);
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/core/gap_fill_linear_interpolator_core.sv
// Processing: a closing item runs a backward scan over the held entries, then
// one interpolation per missing level of each held entry (serial divider).
// Input acceptance stalls only when the 2-entry command queue is full.
// Reset: i_rst_n synchronous active low; clears segment state, the held count,
// the sticky overflow flag and loads edge_value 1024 and edge_margin 42.
// ----------------------------------------------------------------------------
// gap_fill_linear_interpolator_core
// Two-channel sample stream gap filler with segment edge insertion.
// ----------------------------------------------------------------------------
`include "gap_fill_linear_interpolator_core_assert.svh"

module gap_fill_linear_interpolator_core #(
    parameter int HOLD_DEPTH = gfli_pkg::HOLD_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // sample_time, blood_level, tissue_level
    input  logic        s_axis_tlast,   // last_in_segment
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // out_time, out_blood, out_tissue
    output logic        m_axis_tlast,   // end_of_segment
    output logic [1:0]  m_axis_tuser    // is_edge, overflowed
);
    logic           push, q_ready, q_valid, q_pop;
    gfli_pkg::t_cmd f_cmd, q_cmd;
    logic [31:0]    o_t;
    logic [15:0]    o_b, o_s;
    logic           o_e, o_eos, o_ovf;

    gfli_front #(.HOLD_DEPTH(HOLD_DEPTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_time      (s_axis_tdata[31:0]),
        .i_blood     (s_axis_tdata[47:32]),
        .i_tissue    (s_axis_tdata[63:48]),
        .i_last      (s_axis_tlast),
        .o_push      (push),
        .o_cmd       (f_cmd),
        .i_q_ready   (q_ready)
    );

    gfli_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    gfli_back #(.HOLD_DEPTH(HOLD_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_time      (o_t),
        .o_blood     (o_b),
        .o_tissue    (o_s),
        .o_edge      (o_e),
        .o_eos       (o_eos),
        .o_ovf       (o_ovf)
    );

    assign m_axis_tdata = {o_s, o_b, o_t};
    assign m_axis_tlast = o_eos;
    assign m_axis_tuser = {o_ovf, o_e};

    `GFLI_ASSERT_IMP(a_push_room, i_clk, i_rst_n, push, q_ready)
    `GFLI_ASSERT_IMP(a_eos_is_edge, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser[0])
    `GFLI_ASSERT_NXT(a_pop_valid, i_clk, i_rst_n, q_pop && !q_valid, 1'b0)

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// Gap fill interpolator core testbench
// Drives segments of timed two-channel samples, predicts every emitted beat
// (edges, filled and closing samples) and compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH = gfli_pkg::HOLD_DEPTH_DEF;

    typedef struct packed {
        logic [31:0] t;
        logic [15:0] b;
        logic [15:0] s;
        logic        edge_f;
        logic        eos;
        logic        ovf;
    } t_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_addr = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;

    gap_fill_linear_interpolator_core u_top (.*);

    always #4 i_clk = ~i_clk;

    // predictor state
    logic [31:0]      hold_t [DEPTH];
    logic [15:0]      hold_b [DEPTH];
    logic [15:0]      hold_s [DEPTH];
    int               n_held;
    logic [31:0]      ab_t, at_t, bv_t;
    logic [15:0]      ab_l, at_l;
    gfli_pkg::t_phase phase;
    logic [1:0]       seen;
    logic             sticky;
    logic [15:0]      cfg_value, cfg_margin;

    t_beat expected_beats [$];
    int    n_fail = 0;
    bit    rx_stall_en = 1'b1;

    function automatic logic [15:0] lerp(logic [31:0] ta, logic [15:0] a, logic [31:0] tb,
                                         logic [15:0] b, logic [31:0] tc);
        longint den, num, q, r;
        bit neg;
        den = longint'(tb) - longint'(ta);
        num = (longint'(tc) - longint'(ta)) * (longint'(b) - longint'(a));
        if (den == 0) return a;
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        neg = num < 0;
        if (neg) num = -num;
        q = (2 * num + den) / (2 * den);
        if (neg) q = -q;
        r = longint'(a) + q;
        if (r < 1) r = 1;
        if (r > 65535) r = 65535;
        return r[15:0];
    endfunction

    task automatic push_beat(logic [31:0] t, logic [15:0] b, logic [15:0] s,
                             logic e, logic eos);
        t_beat x;
        x = '{t, b, s, e, eos, sticky};
        expected_beats.push_back(x);
    endtask

    task automatic emit_right(logic [15:0] ev);
        logic [32:0] rt;
        rt = {1'b0, bv_t} + {17'd0, cfg_margin};
        if (rt[32]) rt = 33'h0_FFFF_FFFF;
        push_beat(rt[31:0], ev, ev, 1'b1, 1'b1);
        n_held = 0;
        phase = gfli_pkg::PH_WAIT_FIRST;
    endtask

    // one channel fill; sel 0 = blood, 1 = tissue
    task automatic fill_chan(bit sel, logic [31:0] at, logic [15:0] al,
                             logic [31:0] ct, logic [15:0] cl, output logic [15:0] dst [DEPTH]);
        logic [31:0] nt;
        logic [15:0] nl, v;
        for (int k = 0; k < n_held; k++) begin
            v = sel ? hold_s[k] : hold_b[k];
            if (v != 0) begin
                at = hold_t[k];
                al = v;
                dst[k] = v;
            end else begin
                nt = ct;
                nl = cl;
                for (int m = k + 1; m < n_held; m++) begin
                    if ((sel ? hold_s[m] : hold_b[m]) != 0) begin
                        nt = hold_t[m];
                        nl = sel ? hold_s[m] : hold_b[m];
                        break;
                    end
                end
                dst[k] = lerp(at, al, nt, nl, hold_t[k]);
            end
        end
    endtask

    task automatic predict_sample(logic [31:0] t, logic [15:0] b, logic [15:0] s, logic last);
        logic [15:0] ev;
        logic [31:0] et;
        logic [15:0] fb [DEPTH];
        logic [15:0] fs [DEPTH];
        ev = (cfg_value != 0) ? cfg_value : 16'd1;
        if (phase == gfli_pkg::PH_WAIT_FIRST) begin
            et = (t >= {16'd0, cfg_margin}) ? t - {16'd0, cfg_margin} : 32'd0;
            push_beat(et, ev, ev, 1'b1, 1'b0);
            ab_t = et; ab_l = ev; at_t = et; at_l = ev;
            bv_t = t; seen = 2'b00; n_held = 0; phase = gfli_pkg::PH_SEEK;
            if (last) emit_right(ev);
            return;
        end
        if (phase == gfli_pkg::PH_SEEK) begin
            if (b != 0) seen[0] = 1'b1;
            if (s != 0) seen[1] = 1'b1;
            if (seen != 2'b11) begin
                if (last) emit_right(ev);
                return;
            end
            phase = gfli_pkg::PH_COLLECT;
        end
        if (b != 0 && s != 0) begin
            fill_chan(1'b0, ab_t, ab_l, t, b, fb);
            fill_chan(1'b1, at_t, at_l, t, s, fs);
            for (int k = 0; k < n_held; k++) push_beat(hold_t[k], fb[k], fs[k], 1'b0, 1'b0);
            push_beat(t, b, s, 1'b0, 1'b0);
            ab_t = t; ab_l = b; at_t = t; at_l = s; bv_t = t; n_held = 0;
            if (last) emit_right(ev);
            return;
        end
        if (last) begin
            emit_right(ev);
            return;
        end
        if (n_held < DEPTH) begin
            hold_t[n_held] = t; hold_b[n_held] = b; hold_s[n_held] = s;
            n_held++;
        end else begin
            sticky = 1'b1;
        end
    endtask

    // tvalid stays high after the accepting edge when the next beat follows at once
    task automatic send_sample(logic [31:0] t, logic [15:0] b, logic [15:0] s, logic last,
                               bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {s, b, t};
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_sample(t, b, s, last);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (60 * DEPTH + 100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == gfli_pkg::REG_EDGE_VALUE) cfg_value = val;
        else cfg_margin = val;
    endtask

    // output side: random stalls, check in order
    always @(posedge i_clk) begin
        t_beat got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[31:0], m_axis_tdata[47:32], m_axis_tdata[63:48],
                    m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]};
            if (expected_beats.size() == 0) begin
                $error("unexpected beat t=%0d", got.t);
                n_fail++;
            end else begin
                want = expected_beats.pop_front();
                if (got.t !== want.t) begin
                    $error("out_time exp %0d got %0d", want.t, got.t); n_fail++;
                end
                if (got.b !== want.b) begin
                    $error("out_blood exp %0d got %0d", want.b, got.b); n_fail++;
                end
                if (got.s !== want.s) begin
                    $error("out_tissue exp %0d got %0d", want.s, got.s); n_fail++;
                end
                if (got.edge_f !== want.edge_f) begin
                    $error("is_edge exp %0d got %0d", want.edge_f, got.edge_f); n_fail++;
                end
                if (got.eos !== want.eos) begin
                    $error("end_of_segment exp %0d got %0d", want.eos, got.eos); n_fail++;
                end
                if (got.ovf !== want.ovf) begin
                    $error("overflowed exp %0d got %0d", want.ovf, got.ovf); n_fail++;
                end
            end
        end
    end

    initial begin
        int wait_n;
        forever begin
            wait_n = rx_stall_en ? $urandom_range(0, 17) : 0;
            if (wait_n != 0) begin
                m_axis_tready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    function automatic logic [15:0] rand_level();
        case ($urandom_range(0, 5))
            0, 1: return 16'd0;
            2: return 16'hFFFF;
            3: return 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed_edges();
        // one-sample segment at time zero: left edge saturates low
        send_sample(32'd0, 16'd0, 16'd0, 1'b1);
        // right edge saturates high
        send_sample(32'hFFFF_FFF0, 16'h0100, 16'h0200, 1'b0);
        send_sample(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        // no both-valid sample in segment
        send_sample(32'd100, 16'd0, 16'd5, 1'b0);
        send_sample(32'd110, 16'd0, 16'd5, 1'b1);
    endtask

    task automatic test_directed_fill();
        send_sample(32'd1000, 16'd0, 16'd0, 1'b0);
        send_sample(32'd1010, 16'd300, 16'd0, 1'b0);
        send_sample(32'd1020, 16'd0, 16'd400, 1'b0);   // opens frame
        send_sample(32'd1030, 16'd0, 16'd0, 1'b0);
        send_sample(32'd1030, 16'd0, 16'h7FFF, 1'b0);  // equal times
        send_sample(32'd1025, 16'hFFFF, 16'd0, 1'b0);  // out of order
        send_sample(32'd1040, 16'd1, 16'hFFFF, 1'b0);
        send_sample(32'd1050, 16'd0, 16'd9, 1'b0);     // dropped tail
        send_sample(32'd1060, 16'd0, 16'd0, 1'b1);
    endtask

    task automatic test_overflow();
        send_sample(32'd5000, 16'd10, 16'd10, 1'b0);
        send_sample(32'd5001, 16'd10, 16'd10, 1'b0);
        for (int k = 0; k < DEPTH + 2; k++)
            send_sample(32'd5002 + 32'(k), 16'd0, 16'd7, 1'b0, 1'b1);
        send_sample(32'd5100, 16'd20, 16'd30, 1'b1);
    endtask

    task automatic test_random(int n_items);
        logic [31:0] t;
        int len;
        while (n_items > 0) begin
            t = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 1000000);
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 9) == 0) t = $urandom;
                else t = t + $urandom_range(0, 500);
                if ($urandom_range(0, 2) == 0)
                    send_sample(t, 16'($urandom_range(1, 65535)),
                                16'($urandom_range(1, 65535)), k == len - 1);
                else
                    send_sample(t, rand_level(), rand_level(), k == len - 1);
                n_items--;
            end
            if ($urandom_range(0, 9) == 0) wait_drain();
        end
    endtask

    initial begin
        cfg_value = gfli_pkg::EDGE_VALUE_RST;
        cfg_margin = gfli_pkg::EDGE_MARGIN_RST;
        n_held = 0; ab_t = '0; at_t = '0; bv_t = '0; ab_l = '0; at_l = '0;
        phase = gfli_pkg::PH_WAIT_FIRST; seen = '0; sticky = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        wait_drain();
        write_reg(gfli_pkg::REG_EDGE_VALUE, 16'd0);      // zero used as one
        write_reg(gfli_pkg::REG_EDGE_MARGIN, 16'hFFFF);
        test_directed_fill();
        wait_drain();
        write_reg(gfli_pkg::REG_EDGE_VALUE, 16'hFFFF);
        write_reg(gfli_pkg::REG_EDGE_MARGIN, 16'd0);
        test_overflow();
        wait_drain();
        rx_stall_en = 1'b0;
        write_reg(gfli_pkg::REG_EDGE_VALUE, 16'd1);
        write_reg(gfli_pkg::REG_EDGE_MARGIN, 16'd7);
        test_random(40);
        wait_drain();
        rx_stall_en = 1'b1;
        write_reg(gfli_pkg::REG_EDGE_VALUE, 16'($urandom_range(1, 65535)));
        write_reg(gfli_pkg::REG_EDGE_MARGIN, 16'($urandom));
        test_random(85);
        wait_drain();

        if (n_fail == 0 && expected_beats.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/gfli_pkg.sv
rtl/core/gfli_front.sv
rtl/core/gfli_queue.sv
rtl/core/gfli_interp.sv
rtl/core/gfli_back.sv
rtl/core/gap_fill_linear_interpolator_core.sv
bench/tb.sv
